// ===== hdl/size_class_object_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// size class object allocator assertion macros
// shared concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_OBJECT_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_OBJECT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define SCOA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scoa assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define SCOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scoa assertion failed");
`else
`define SCOA_ASSERT(lbl, prop)
`define SCOA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/scoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoa_pkg
// sizes, status codes and class tables of the size class object allocator
// ----------------------------------------------------------------------------
package scoa_pkg;

  // object and slab geometry
  localparam int SMALLEST_ORDER = 4;
  localparam int LARGEST_ORDER  = 11;
  localparam int SLAB_ORDER     = 12;

  localparam int MAX_CLASSES = 8;
  localparam int CLS_W       = 3;
  localparam int SLOT_W      = 8;
  localparam int CNT_W       = 9;
  localparam int SIZE_W      = 16;
  localparam int CMP_W       = 17;
  localparam int ADDR_W      = CLS_W + SLOT_W;
  localparam int STACK_DEPTH = MAX_CLASSES * (1 << SLOT_W);

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_FIELD_W = 2 + CLS_W + SLOT_W + CNT_W;

  // operation codes carried in tuser
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef logic [MAX_CLASSES-1:0][CNT_W-1:0] cnt_arr_t;

  // one request's effect, from the decision logic to the state and pipeline
  typedef struct packed {
    status_t              status;
    logic [CLS_W-1:0]     cls;
    logic [SLOT_W-1:0]    idx;
    logic [CNT_W-1:0]     left;
    logic                 pop;
    logic                 push;
    logic                 use_mem;
  } decision_t;

  function automatic int class_count();
    int n;
    n = LARGEST_ORDER - SMALLEST_ORDER + 1;
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    return n;
  endfunction

  localparam int NUM_CLASSES = class_count();
  localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(1 << LARGEST_ORDER);

  // slots per class slab, capped at the stack depth
  function automatic logic [CNT_W-1:0] class_cap(input logic [CLS_W-1:0] c);
    int ord;
    ord = SMALLEST_ORDER + int'(c);
    if (ord > SLAB_ORDER) return '0;
    if (SLAB_ORDER - ord >= SLOT_W) return CNT_W'(1 << SLOT_W);
    return CNT_W'(1 << (SLAB_ORDER - ord));
  endfunction

  function automatic logic [CMP_W-1:0] obj_size(input logic [CLS_W-1:0] c);
    return CMP_W'(1 << (SMALLEST_ORDER + int'(c)));
  endfunction

  function automatic logic [CNT_W-1:0] reset_count(input logic [CLS_W-1:0] c);
    return (int'(c) < NUM_CLASSES) ? class_cap(c) : '0;
  endfunction

endpackage

// ===== hdl/scoa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoa_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module scoa_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 2048,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/scoa_decide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scoa_decide
// class pick and count update for one allocate or free request
// ----------------------------------------------------------------------------
module scoa_decide
  import scoa_pkg::*;
(
  input  logic              op_mode,
  input  logic [SIZE_W-1:0] request_size,
  input  logic [CLS_W-1:0]  free_class,
  input  cnt_arr_t          cnt,
  input  cnt_arr_t          low_mark,
  output decision_t         dec
);

  logic              found;
  logic [CLS_W-1:0]  sel;
  logic [CLS_W-1:0]  tgt;
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  cur_lw;
  logic [CNT_W-1:0]  cur_m1;
  logic [CNT_W-1:0]  cur_p1;
  logic [CNT_W-1:0]  cur_cap;
  logic [CMP_W-1:0]  size_ext;

  assign size_ext = {1'b0, request_size};

  // lowest class that fits and still has a free slot
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (size_ext <= obj_size(CLS_W'(c)) && cnt[c] != '0) begin
        found = 1'b1;
        sel   = CLS_W'(c);
      end
    end
  end

  // one count read for the affected class
  assign tgt     = (op_mode == MODE_ALLOC) ? sel : free_class;
  assign cur     = cnt[tgt];
  assign cur_lw  = low_mark[tgt];
  assign cur_m1  = cur - CNT_W'(1);
  assign cur_p1  = cur + CNT_W'(1);
  assign cur_cap = class_cap(tgt);

  // request outcome
  always_comb begin
    dec        = '0;
    dec.status = ST_OK;
    dec.cls    = tgt;
    if (op_mode == MODE_ALLOC) begin
      if (size_ext > MAX_SIZE) begin
        dec.status = ST_OVERSIZE;
      end else if (!found) begin
        dec.status = ST_NO_FIT;
      end else begin
        dec.pop     = 1'b1;
        dec.idx     = cur_m1[SLOT_W-1:0];
        dec.left    = cur_m1;
        // entries below the low mark were never rewritten
        dec.use_mem = (cur_lw <= cur_m1);
      end
    end else begin
      if (32'(free_class) >= NUM_CLASSES) begin
        dec.status = ST_FULL;
      end else if (cur >= cur_cap) begin
        dec.status = ST_FULL;
        dec.left   = cur;
      end else begin
        dec.push = 1'b1;
        dec.idx  = cur[SLOT_W-1:0];
        dec.left = cur_p1;
      end
    end
  end

endmodule

// ===== hdl/size_class_object_allocator.sv =====
`timescale 1ns / 1ps
// path: an accepted request is registered in the read stage, then in the result register that drives out_tvalid
// throughput: one request per cycle while out_tready keeps the result register moving
// reset: every class stack is full and reads back slot j at entry j; a per-class
// low-water mark stands in for a clear of the 2048-entry ram, so no clearing pass
// ----------------------------------------------------------------------------
// size_class_object_allocator
// eight size classes with lifo free stacks, allocate and free over streams
// ----------------------------------------------------------------------------
`include "size_class_object_allocator_macros.svh"

module size_class_object_allocator
  import scoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // request_size[15:0], free_class[18:16], free_slot[26:19], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic [0:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[1:0], granted_class[4:2], granted_slot[12:5], free_left[21:13], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [SIZE_W-1:0] in_size;
  logic [CLS_W-1:0]  in_free_class;
  logic [SLOT_W-1:0] in_free_slot;

  cnt_arr_t          cnt_r;
  cnt_arr_t          lw_r;
  decision_t         dec;

  logic              accept;
  logic              s1_adv;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [SLOT_W-1:0] ram_q;

  logic              s1_valid_r;
  status_t           s1_status_r;
  logic [CLS_W-1:0]  s1_cls_r;
  logic [SLOT_W-1:0] s1_idx_r;
  logic [CNT_W-1:0]  s1_left_r;
  logic              s1_pop_r;
  logic              s1_mem_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;
  logic [CLS_W-1:0]       gcls;
  logic [SLOT_W-1:0]      gslot;

  // request fields
  assign in_size       = in_tdata[SIZE_W-1:0];
  assign in_free_class = in_tdata[SIZE_W+CLS_W-1:SIZE_W];
  assign in_free_slot  = in_tdata[SIZE_W+CLS_W+SLOT_W-1:SIZE_W+CLS_W];

  // handshake: result register and read stage move together
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  scoa_decide u_decide (
    .op_mode      (in_tuser[0]),
    .request_size (in_size),
    .free_class   (in_free_class),
    .cnt          (cnt_r),
    .low_mark     (lw_r),
    .dec          (dec)
  );

  // free stack store
  assign ram_we   = accept && dec.push;
  assign ram_re   = accept && dec.pop;
  assign ram_addr = {dec.cls, dec.idx};

  scoa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data (in_free_slot),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_q)
  );

  // free counts and low-water marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        cnt_r[c] <= reset_count(CLS_W'(c));
        lw_r[c]  <= reset_count(CLS_W'(c));
      end
    end else if (accept) begin
      for (int c = 0; c < MAX_CLASSES; c++) begin
        if (dec.cls == CLS_W'(c) && (dec.pop || dec.push)) begin
          cnt_r[c] <= dec.left;
        end
        if (dec.cls == CLS_W'(c) && dec.pop && dec.left < lw_r[c]) begin
          lw_r[c] <= dec.left;
        end
      end
    end
  end

  // read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= dec.status;
      s1_cls_r    <= dec.cls;
      s1_idx_r    <= dec.idx;
      s1_left_r   <= dec.left;
      s1_pop_r    <= dec.pop;
      s1_mem_r    <= dec.use_mem;
    end
  end

  // result fields, slot from ram or from the untouched reset pattern
  assign gcls  = s1_pop_r ? s1_cls_r : '0;
  assign gslot = s1_pop_r ? (s1_mem_r ? ram_q : s1_idx_r) : '0;

  assign out_tdata_nxt = {(OUT_TDATA_W - OUT_FIELD_W)'(0), s1_left_r, gslot, gcls, s1_status_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `SCOA_ASSERT(a_ram_one_op, !(ram_we && ram_re))
  `SCOA_ASSERT(a_fail_no_grant, !(out_tvalid && out_tdata[1:0] != ST_OK) || out_tdata[12:2] == '0)
  `SCOA_ASSERT_NEXT(a_stage_holds, s1_valid_r && !s1_adv, s1_valid_r)

  for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_cls_chk
    `SCOA_ASSERT(a_low_mark, lw_r[g] <= cnt_r[g])
    `SCOA_ASSERT(a_count_cap, cnt_r[g] <= class_cap(CLS_W'(g)))
  end

endmodule

// ===== sim/tb_size_class_object_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_object_allocator
// drives allocate and free requests into the size class allocator and checks
// every result against an in-order predictor of the class stacks and counts;
// a directed opening covers size and slot extremes, exhaustion and full-class
// frees, then random phases swing between allocate-heavy and free-heavy load
// ----------------------------------------------------------------------------
module tb_size_class_object_allocator;
  import scoa_pkg::*;

  localparam int CLASS_SPAN = LARGEST_ORDER - SMALLEST_ORDER + 1;
  localparam int N_CLASSES  = (CLASS_SPAN < 1) ? 1 :
                              (CLASS_SPAN > MAX_CLASSES) ? MAX_CLASSES : CLASS_SPAN;
  localparam int SLOTS      = 1 << SLOT_W;
  localparam int BATCH      = 50;
  localparam int N_BATCHES  = 35;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } alloc_req_t;

  typedef struct {
    status_t           status;
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  left;
  } alloc_rsp_t;

  typedef struct {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } obj_ref_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // requests waiting for the driver, results owed by the block, objects held
  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_results[$];
  obj_ref_t   live_objects[$];

  // shadow of the per-class free stacks and counts
  logic [SLOT_W-1:0] free_stack [MAX_CLASSES][SLOTS];
  logic [CNT_W-1:0]  free_cnt [MAX_CLASSES];

  int  n_grants, n_frees, n_oversize, n_no_fit, n_refused;
  int  n_results, n_errors;
  int  gap_left, stall_left, hold_left, idle_cycles;
  bit  calm, hold_req, hold_done;

  size_class_object_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // slots in one class slab, capped at the stack depth
  function automatic int slab_slots(input int c);
    int ord;
    ord = SMALLEST_ORDER + c;
    if (ord > SLAB_ORDER) return 0;
    if (SLAB_ORDER - ord >= SLOT_W) return SLOTS;
    return 1 << (SLAB_ORDER - ord);
  endfunction

  // applies one request to the shadow state and records the owed result
  task automatic predict_allocation(input alloc_req_t r);
    alloc_rsp_t e;
    obj_ref_t   o;
    bit         found;
    e.status = ST_OK;
    e.cls    = '0;
    e.slot   = '0;
    e.left   = '0;
    found    = 1'b0;
    if (r.mode == MODE_ALLOC) begin
      if (int'(r.size) > (1 << LARGEST_ORDER)) begin
        e.status = ST_OVERSIZE;
        n_oversize++;
      end else begin
        // lowest class that fits and still has a free slot
        for (int c = 0; c < N_CLASSES && !found; c++) begin
          if (int'(r.size) <= (1 << (SMALLEST_ORDER + c)) && free_cnt[c] != '0) begin
            free_cnt[c] = free_cnt[c] - 1'b1;
            e.cls  = CLS_W'(c);
            e.slot = free_stack[c][free_cnt[c][SLOT_W-1:0]];
            e.left = free_cnt[c];
            found  = 1'b1;
          end
        end
        if (found) begin
          o.cls  = e.cls;
          o.slot = e.slot;
          live_objects.push_back(o);
          n_grants++;
        end else begin
          e.status = ST_NO_FIT;
          n_no_fit++;
        end
      end
    end else if (int'(r.cls) >= N_CLASSES) begin
      e.status = ST_FULL;
      n_refused++;
    end else if (int'(free_cnt[r.cls]) >= slab_slots(int'(r.cls))) begin
      e.status = ST_FULL;
      e.left   = free_cnt[r.cls];
      n_refused++;
    end else begin
      free_stack[r.cls][free_cnt[r.cls][SLOT_W-1:0]] = r.slot;
      free_cnt[r.cls] = free_cnt[r.cls] + 1'b1;
      e.left = free_cnt[r.cls];
      n_frees++;
    end
    expected_results.push_back(e);
  endtask

  task automatic queue_req(input logic mode, input int size, input int cls, input int slot);
    alloc_req_t r;
    r.mode = mode;
    r.size = SIZE_W'(size);
    r.cls  = CLS_W'(cls);
    r.slot = SLOT_W'(slot);
    pending_reqs.push_back(r);
  endtask

  // request sizes weighted toward the class boundaries
  function automatic int random_size();
    int pick;
    int ord;
    pick = $urandom_range(0, 99);
    ord  = $urandom_range(SMALLEST_ORDER, LARGEST_ORDER);
    if (pick < 65) return $urandom_range(0, 1 << ord);
    if (pick < 80) return (1 << ord) + $urandom_range(0, 1);
    if (pick < 92) return $urandom_range((1 << LARGEST_ORDER) + 1, 65535);
    return $urandom & 16'hFFFF;
  endfunction

  // request driver, predicts each request as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
      for (int c = 0; c < MAX_CLASSES; c++) begin
        free_cnt[c] = (c < N_CLASSES) ? CNT_W'(slab_slots(c)) : '0;
        for (int j = 0; j < SLOTS; j++) free_stack[c][j] = SLOT_W'(j);
      end
    end else begin
      if (in_tvalid && in_tready) predict_allocation(pending_reqs.pop_front());
      if (in_tvalid && !in_tready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 4);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'({pending_reqs[0].slot, pending_reqs[0].cls,
                                  pending_reqs[0].size});
        in_tuser  <= pending_reqs[0].mode;
      end
    end
  end

  // result receiver, random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 79;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result tdata=%h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[1:0] !== want.status || out_tdata[4:2] !== want.cls ||
            out_tdata[12:5] !== want.slot || out_tdata[21:13] !== want.left) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"result %0d mismatch: expected status=%0d class=%0d slot=%0d",
                      " left=%0d, got status=%0d class=%0d slot=%0d left=%0d"},
                     n_results, want.status, want.cls, want.slot, want.left,
                     out_tdata[1:0], out_tdata[4:2], out_tdata[12:5], out_tdata[21:13]);
        end
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("FAIL size_class_object_allocator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int       pct;
    int       k;
    obj_ref_t o;
    int       alloc_pct [7];
    alloc_pct = '{90, 35, 95, 20, 80, 50, 60};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // size extremes, class 7 exhaustion, oversize, full-class frees
    queue_req(MODE_ALLOC, 0, 0, 0);
    queue_req(MODE_ALLOC, 16, 0, 0);
    queue_req(MODE_ALLOC, 17, 0, 0);
    queue_req(MODE_ALLOC, 2048, 0, 0);
    queue_req(MODE_ALLOC, 2048, 0, 0);
    queue_req(MODE_ALLOC, 2048, 0, 0);
    queue_req(MODE_ALLOC, 1025, 0, 0);
    queue_req(MODE_ALLOC, 2049, 0, 0);
    queue_req(MODE_ALLOC, 65535, 0, 0);
    queue_req(MODE_ALLOC, 32768, 0, 0);
    // slot beyond the class capacity goes back on the stack as given
    queue_req(MODE_FREE, 0, 7, 255);
    queue_req(MODE_ALLOC, 2000, 0, 0);
    queue_req(MODE_FREE, 0, 2, 5);
    queue_req(MODE_FREE, 0, 6, 3);
    queue_req(MODE_ALLOC, 1024, 0, 0);
    queue_req(MODE_ALLOC, 512, 0, 0);
    queue_req(MODE_FREE, 0, 7, 0);
    queue_req(MODE_FREE, 0, 7, 1);
    queue_req(MODE_FREE, 0, 7, 2);
    queue_req(MODE_ALLOC, 2048, 0, 0);
    queue_req(MODE_FREE, 0, 0, 0);
    queue_req(MODE_FREE, 0, 0, 255);
    while (pending_reqs.size() != 0) @(negedge clk);

    // random phases, frees mostly return objects actually held
    for (int b = 0; b < N_BATCHES; b++) begin
      pct = alloc_pct[(b / 5) % 7];
      if (b == 8) hold_req = 1'b1;
      if (b == N_BATCHES - 5) calm = 1'b1;
      for (int i = 0; i < BATCH; i++) begin
        if ($urandom_range(0, 99) < pct) begin
          queue_req(MODE_ALLOC, random_size(), 0, 0);
        end else if (live_objects.size() != 0 && $urandom_range(0, 99) < 85) begin
          k = $urandom_range(0, live_objects.size() - 1);
          o = live_objects[k];
          live_objects.delete(k);
          queue_req(MODE_FREE, $urandom & 16'hFFFF, int'(o.cls), int'(o.slot));
        end else begin
          queue_req(MODE_FREE, $urandom & 16'hFFFF, $urandom_range(0, 7),
                    $urandom_range(0, 255));
        end
      end
      while (pending_reqs.size() != 0) @(negedge clk);
    end

    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("%0d results checked: %0d grants, %0d frees, %0d oversize, %0d no fit",
             n_results, n_grants, n_frees, n_oversize, n_no_fit);
    $display("%0d frees refused as full, %0d mismatches", n_refused, n_errors);
    if (n_errors == 0) begin
      $display("PASS size_class_object_allocator");
    end else begin
      $display("FAIL size_class_object_allocator");
    end
    $finish;
  end

endmodule
